// ----- rtl/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// hse_pkg: shared definitions for the heap sort engine
// Holds the data width, the default capacity and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // Sequencer states
    typedef enum logic [3:0] {
        S_LOAD,      // take input requests into the store
        S_BLD_NEXT,  // pick the next parent to sift during heap build
        S_BLD_RD,    // capture the parent value being sifted
        S_SIFT_RD,   // read both children of the current node
        S_SIFT_CMP,  // compare children and the sifted value, move one level
        S_EXT_NEXT,  // read root and last leaf of the shrinking heap
        S_EXT_SWAP,  // park the root at the end, start sifting the leaf value
        S_EM_RD,     // read the next result from the store
        S_EM_LD,     // load the output register
        S_EM_WAIT    // hold the result until the receiver takes it
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/heap_sort_engine.sv -----
// ----------------------------------------------------------------------------
// heap_sort_engine: in-place heapsort of signed 32-bit values
// Collects a set of values, sorts them with a shared sift-down unit over a
// dual-read store and streams the result out.
// ----------------------------------------------------------------------------
// Usage:
//   Values enter on the s_axis channel, one request per cycle while loading.
//   s_axis_tlast marks the final value of a set and starts the sort. Values
//   beyond MAX_ITEMS are dropped; every result of that set then carries
//   m_axis_tuser = 1. The set (1 to MAX_ITEMS values) leaves on m_axis in
//   ascending order, or in built max-heap order when the configuration bit
//   emit_heap_order is 1 (write it through i_cfg_wen/i_cfg_wdata while idle).
//   m_axis_tlast marks the final result of the set.
// Operation:
//   After the last value the sequencer runs one shared compare unit over the
//   store: it reads and captures each parent to start a sift, reads both
//   children and compares them to move each tree level, and reads the root and
//   last leaf, then parks the root at the end, to start each extraction. Each
//   result is then read from the store and loaded into the output register.
//   s_axis_tready is low from the last value until the final result is taken;
//   the output register holds its request while m_axis_tready is low.
// Reset:
//   i_rst_n (synchronous, active low) empties the set, clears the overflow
//   flag and the configuration bit. The store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine
    import hse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // configuration: emit_heap_order
    input  wire logic                     i_cfg_wen,
    input  wire logic                     i_cfg_wdata,
    // input stream
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic signed [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  wire logic                     s_axis_tlast,   // last_item
    // output stream
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic signed [DATA_W-1:0]      m_axis_tdata,   // [31:0] sorted_value
    output logic                          m_axis_tlast,   // last_result
    output logic                          m_axis_tuser    // [0] overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

    // State and registers
    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_mode;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_hn, n_hn;
    logic          r_extract, n_extract;
    logic signed [DATA_W-1:0] r_pv, n_pv;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic          r_out_valid, n_out_valid;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    // Store ports
    logic signed [DATA_W-1:0] mem [MAX_ITEMS];
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic signed [DATA_W-1:0] mem_wd;
    logic [AW-1:0]            mem_ra, mem_rb;
    logic signed [DATA_W-1:0] rd_a, rd_b;

    // Sift unit
    logic [CW:0]              w_lidx, w_ridx;
    logic                     w_has_left, w_has_right;
    logic                     w_pick_right, w_go_down;
    logic [CW-1:0]            w_cidx;
    logic signed [DATA_W-1:0] w_cval;
    logic                     w_in_acc, w_out_acc, w_res_last;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = r_out_valid && m_axis_tready;

    // Compare the two children, then the larger child with the sifted value
    always_comb begin
        w_lidx       = {r_i, 1'b1};
        w_ridx       = {r_i, 1'b0} + (CW+1)'(2);
        w_has_left   = w_lidx < {1'b0, r_hn};
        w_has_right  = w_ridx < {1'b0, r_hn};
        w_pick_right = w_has_right && (rd_b > rd_a);
        w_cval       = w_pick_right ? rd_b : rd_a;
        w_cidx       = w_pick_right ? w_ridx[CW-1:0] : w_lidx[CW-1:0];
        w_go_down    = w_cval > r_pv;
        w_res_last   = (r_k + CW'(1)) == r_cnt;
    end

    // Store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_a <= mem[mem_ra];
        rd_b <= mem[mem_rb];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && s_axis_tlast) n_state = S_BLD_NEXT;
            end
            S_BLD_NEXT: begin
                if (r_k != '0)            n_state = S_BLD_RD;
                else if (r_mode)          n_state = S_EM_RD;
                else                      n_state = S_EXT_NEXT;
            end
            S_BLD_RD:   n_state = S_SIFT_RD;
            S_SIFT_RD: begin
                if (w_has_left)           n_state = S_SIFT_CMP;
                else if (r_extract)       n_state = S_EXT_NEXT;
                else                      n_state = S_BLD_NEXT;
            end
            S_SIFT_CMP: begin
                if (w_go_down)            n_state = S_SIFT_RD;
                else if (r_extract)       n_state = S_EXT_NEXT;
                else                      n_state = S_BLD_NEXT;
            end
            S_EXT_NEXT: begin
                if (r_k < CW'(2))         n_state = S_EM_RD;
                else                      n_state = S_EXT_SWAP;
            end
            S_EXT_SWAP: n_state = S_SIFT_RD;
            S_EM_RD:    n_state = S_EM_LD;
            S_EM_LD:    n_state = S_EM_WAIT;
            S_EM_WAIT: begin
                if (w_out_acc) n_state = r_out_last ? S_LOAD : S_EM_RD;
            end
            default:    n_state = S_LOAD;
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_i         = r_i;
        n_hn        = r_hn;
        n_extract   = r_extract;
        n_pv        = r_pv;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_wa      = r_i[AW-1:0];
        mem_wd      = r_pv;
        mem_ra      = w_lidx[AW-1:0];
        mem_rb      = w_ridx[AW-1:0];
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                s_axis_tready = 1'b1;
                mem_wa        = r_cnt[AW-1:0];
                mem_wd        = s_axis_tdata;
                if (w_in_acc) begin
                    // store while room remains, else drop and flag
                    if (r_cnt < CAP) begin
                        mem_we = 1'b1;
                        n_cnt  = r_cnt + CW'(1);
                    end else begin
                        n_ovf  = 1'b1;
                    end
                    n_k       = n_cnt >> 1;
                    n_extract = 1'b0;
                end
            end
            S_BLD_NEXT: begin
                // read the next parent, or move on to extraction (to emission in heap order mode)
                mem_ra = AW'(r_k - CW'(1));
                if (r_k != '0) begin
                    n_i  = r_k - CW'(1);
                    n_hn = r_cnt;
                    n_k  = r_k - CW'(1);
                end else if (r_mode) begin
                    n_k = '0;
                end else begin
                    n_k       = r_cnt;
                    n_extract = 1'b1;
                end
            end
            S_BLD_RD: begin
                n_pv = rd_a;
            end
            S_SIFT_RD: begin
                // leaf reached: drop the sifted value in place
                if (!w_has_left) begin
                    mem_we = 1'b1;
                end
            end
            S_SIFT_CMP: begin
                mem_we = 1'b1;
                if (w_go_down) begin
                    mem_wd = w_cval;
                    n_i    = w_cidx;
                end
            end
            S_EXT_NEXT: begin
                mem_ra = '0;
                mem_rb = AW'(r_k - CW'(1));
                if (r_k < CW'(2)) begin
                    n_k = '0;
                end
            end
            S_EXT_SWAP: begin
                // park the root at the end, sift the old last value from the top
                mem_we = 1'b1;
                mem_wa = AW'(r_k - CW'(1));
                mem_wd = rd_a;
                n_pv   = rd_b;
                n_i    = '0;
                n_hn   = r_k - CW'(1);
                n_k    = r_k - CW'(1);
            end
            S_EM_RD: begin
                mem_ra = r_k[AW-1:0];
            end
            S_EM_LD: begin
                n_out_data  = rd_a;
                n_out_last  = w_res_last;
                n_out_ovf   = r_ovf;
                n_out_valid = 1'b1;
            end
            S_EM_WAIT: begin
                if (w_out_acc) begin
                    n_out_valid = 1'b0;
                    n_k         = r_k + CW'(1);
                    if (r_out_last) begin
                        n_cnt = '0;
                        n_ovf = 1'b0;
                    end
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
            r_extract   <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_extract   <= n_extract;
            r_k         <= n_k;
            if (i_cfg_wen) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_hn       <= n_hn;
        r_pv       <= n_pv;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

endmodule

`default_nettype wire

// ----- sim/heap_sort_engine_test.sv -----
// ----------------------------------------------------------------------------
// heap_sort_engine_test: self-checking bench for the heap sort engine
// Streams sets of signed values into the engine and checks every result
// against a behavioral heapsort kept inside the bench, or against the table
// for single-value rows. A short table covers the value extremes, ties and
// single-value sets in both emit modes. Random sets follow, among them full
// sets and sets that overflow the store, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine_test
    import hse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_ITEMS      = MAX_ITEMS_DEF;
    localparam int          DIRECTED_ROWS  = 12;
    localparam int          PHASES         = 6;
    localparam int          SMALL_PER_PH   = 32;
    localparam bit [5:0]    PHASE_MODES    = 6'b10_1100;  // emit mode per phase
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_result;
        logic                     overflow;
    } t_sort_result;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     typed;   // want holds the expected single result
        logic signed [DATA_W-1:0] want;
    } t_dir_row;

    // DUT signals
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wen     = 1'b0;
    logic                     i_cfg_wdata   = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic signed [DATA_W-1:0] s_axis_tdata  = '0;   // [31:0] value
    logic                     s_axis_tlast  = 1'b0; // last_item
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic signed [DATA_W-1:0] m_axis_tdata;         // [31:0] sorted_value
    logic                     m_axis_tlast;         // last_result
    logic                     m_axis_tuser;         // [0] overflow

    // Behavioral sorter state
    logic signed [DATA_W-1:0] held_vals [MAX_ITEMS];
    int unsigned              held_count     = 0;
    bit                       held_ovf       = 1'b0;
    bit                       cfg_heap_order = 1'b0;

    t_sort_result pending_results [$];
    int           fail_count  = 0;
    bit           src_held    = 1'b0;
    bit           idle_on     = 1'b1;
    int           sink_stall  = 0;
    int           idle_cycles = 0;

    heap_sort_engine #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sift node i down within the first n held values
    function automatic void sift_down(input int unsigned n, input int unsigned i);
        int unsigned              top;
        logic signed [DATA_W-1:0] t;
        forever begin
            top = i;
            if (2 * i + 1 < n && held_vals[2 * i + 1] > held_vals[top]) top = 2 * i + 1;
            if (2 * i + 2 < n && held_vals[2 * i + 2] > held_vals[top]) top = 2 * i + 2;
            if (top == i) return;
            t              = held_vals[i];
            held_vals[i]   = held_vals[top];
            held_vals[top] = t;
            i              = top;
        end
    endfunction

    // Take one accepted request; on the last one heapsort the set and queue its results
    function automatic void predict_item(input logic signed [DATA_W-1:0] v,
                                         input logic lst, input bit record);
        t_sort_result             r;
        logic signed [DATA_W-1:0] t;
        int unsigned              k;
        int unsigned              size;
        if (held_count < MAX_ITEMS) begin
            held_vals[held_count] = v;
            held_count++;
        end else begin
            held_ovf = 1'b1;
        end
        if (!lst) return;
        if (held_count >= 2) begin
            for (k = held_count / 2; k > 0; k--) sift_down(held_count, k - 1);
            if (!cfg_heap_order) begin
                // park the root behind the shrinking heap and restore it
                for (size = held_count; size > 1; size--) begin
                    t                  = held_vals[0];
                    held_vals[0]       = held_vals[size - 1];
                    held_vals[size - 1] = t;
                    sift_down(size - 1, 0);
                end
            end
        end
        for (k = 0; k < held_count; k++) begin
            r.sorted_value = held_vals[k];
            r.last_result  = (k + 1 == held_count);
            r.overflow     = held_ovf;
            if (record) pending_results.push_back(r);
        end
        held_count = 0;
        held_ovf   = 1'b0;
    endfunction

    // Directed stimulus rows: value, last, typed, expected single result
    function automatic t_dir_row directed_row(input int k);
        t_dir_row row;
        case (k)
            // single-value sets at the extremes and at -1 come back unchanged
            0:       row = {32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000};
            1:       row = {32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff};
            2:       row = {32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff};
            // extremes mixed with values around zero
            3:       row = {32'h7fff_ffff, 1'b0, 1'b0, 32'h0};
            4:       row = {32'h8000_0000, 1'b0, 1'b0, 32'h0};
            5:       row = {32'hffff_ffff, 1'b0, 1'b0, 32'h0};
            6:       row = {32'h0000_0000, 1'b0, 1'b0, 32'h0};
            7:       row = {32'h0000_0001, 1'b1, 1'b0, 32'h0};
            // ties between parent and children
            8:       row = {32'h0000_0007, 1'b0, 1'b0, 32'h0};
            9:       row = {32'hffff_fffd, 1'b0, 1'b0, 32'h0};
            10:      row = {32'h0000_0007, 1'b0, 1'b0, 32'h0};
            default: row = {32'h0000_0007, 1'b1, 1'b0, 32'h0};
        endcase
        return row;
    endfunction

    // Mostly full-range values, with some small values for ties and the extremes
    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return int'($urandom_range(0, 6)) - 3;
            1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Present one request, hold it until accepted, then predict it
    task automatic send_value(input logic signed [DATA_W-1:0] v, input logic lst,
                              input bit typed = 1'b0,
                              input logic signed [DATA_W-1:0] want = '0);
        t_sort_result r;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            if (src_held) begin
                s_axis_tvalid <= 1'b0;
                src_held = 1'b0;
            end
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= lst;
        src_held = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) begin
            r.sorted_value = want;
            r.last_result  = 1'b1;
            r.overflow     = 1'b0;
            pending_results.push_back(r);
        end
        predict_item(v, lst, !typed);
    endtask

    task automatic send_set(input int n);
        int i;
        for (i = 0; i < n; i++) send_value(rand_value(), i == n - 1);
    endtask

    // Drop valid and wait until every queued result has left the engine
    task automatic drain_results(input int settle);
        if (src_held) begin
            s_axis_tvalid <= 1'b0;
            src_held = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_emit_mode(input bit mode);
        drain_results(SETTLE_CYCLES);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        cfg_heap_order = mode;
    endtask

    function automatic void report_field(input string field, input longint want,
                                         input longint got);
        fail_count++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // Receiver: random stall bursts until the last phase
    always @(posedge i_clk) begin
        if (sink_stall > 0)
            sink_stall = sink_stall - 1;
        else if (idle_on && $urandom_range(0, 11) == 0)
            sink_stall = $urandom_range(1, 19);
        m_axis_tready <= (sink_stall == 0);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_sort_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t ns: unexpected result, expected none, got %0d last %0b ovf %0b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.sorted_value)
                    report_field("sorted_value", want.sorted_value, m_axis_tdata);
                if (m_axis_tlast !== want.last_result)
                    report_field("last_result", want.last_result, m_axis_tlast);
                if (m_axis_tuser !== want.overflow)
                    report_field("overflow", want.overflow, m_axis_tuser);
            end
        end
    end

    // Watchdog: end the run after too long without any request moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Main sequence
    initial begin : stimulus
        t_dir_row row;
        int       pass;
        int       k;
        int       phase;
        int       sent;
        int       n;
        int       big;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table once in each emit mode
        for (pass = 0; pass < 2; pass++) begin
            if (pass == 1) write_emit_mode(1'b1);
            for (k = 0; k < DIRECTED_ROWS; k++) begin
                row = directed_row(k);
                send_value(row.value, row.last, row.typed, row.want);
            end
        end

        // Random sets; one full or overflowing set in some phases
        for (phase = 0; phase < PHASES; phase++) begin
            write_emit_mode(PHASE_MODES[phase]);
            idle_on = (phase != PHASES - 1);
            case (phase)
                1:       big = MAX_ITEMS + 1;
                2:       big = MAX_ITEMS;
                3:       big = MAX_ITEMS + 3;
                default: big = 0;
            endcase
            if (big != 0) send_set(big);
            sent = 0;
            while (sent < SMALL_PER_PH) begin
                n = $urandom_range(1, 12);
                send_set(n);
                sent += n;
            end
        end

        drain_results(4 * SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
